[rtl/core/veg_pkg.sv]
// ----------------------------------------------------------------------------
// veg_pkg
// Shared constants for the 3x3 horizontal-gradient filter.
// ----------------------------------------------------------------------------
package veg_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_COL_W = 10;
	localparam int OUT_ROW_W = 10;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// common width for counter / limit compares
	localparam int CMPC_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int CMPR_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

	localparam int OUT_DATA_W = ((PIX_W + OUT_COL_W + OUT_ROW_W + 7) / 8) * 8;

	// line store entry: {upper, middle}
	localparam int LINE_W = 2 * PIX_W;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

	localparam logic [PIX_W-1:0] MAG_SAT = '1;

endpackage

[rtl/core/veg_ram.sv]
// ----------------------------------------------------------------------------
// veg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module veg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/vertical_edge_3x3_gradient.sv]
// ----------------------------------------------------------------------------
// vertical_edge_3x3_gradient
// Horizontal 3x3 gradient |2*left - 2*right| on a raster gray stream,
// saturated to 255, tagged with the window center column and row.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid/tready      tdata: pixel_gray, tuser: frame_start
//  m_*       out        tvalid/tready      tdata: edge_magnitude, out_column, out_row
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
//  One pixel per clock sustained while the output is not stalled. A request is
//  read from the line-store RAM at accept, combined with the window taps in
//  stage 1 and written back; the result is then held in the output register.
//  Border pixels give no result. A write to an entry still in flight is
//  forwarded past the RAM. Reset clears counters, taps and valid flags; the
//  line store is not cleared. A stalled output holds the stage behind it.
// ----------------------------------------------------------------------------
module vertical_edge_3x3_gradient (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [veg_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_gray
	input  logic                            s_tuser,   // [0] frame_start

	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [veg_pkg::OUT_DATA_W-1:0]  m_tdata,   // [7:0] edge_magnitude,
	                                                   // [17:8] out_column,
	                                                   // [27:18] out_row, rest zero

	input  logic                            cfg_we,
	input  logic [veg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [veg_pkg::CFG_W-1:0]       cfg_data
);

	import veg_pkg::*;

	// configuration
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CMPC_W-1:0] w_lim;
	logic [CMPR_W-1:0] h_lim;

	assign w_lim = (CMPC_W'(width_q) > CMPC_W'(MAX_WIDTH)) ? CMPC_W'(MAX_WIDTH)
	                                                       : CMPC_W'(width_q);
	assign h_lim = (CMPR_W'(height_q) > CMPR_W'(MAX_HEIGHT)) ? CMPR_W'(MAX_HEIGHT)
	                                                         : CMPR_W'(height_q);

	// handshake
	logic s1_valid_q;
	logic emit_s1;
	logic out_valid_q;
	logic s1_adv;
	logic s_acc;

	assign s1_adv   = s1_valid_q && (!emit_s1 || !out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign s_acc    = s_tvalid && s_tready;

	// position counters
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  c_cur;
	logic [ROW_W-1:0]  r_cur;
	logic [CMPC_W-1:0] c_inc;
	logic [CMPR_W-1:0] r_inc;
	logic              emit_cur;

	assign c_cur = s_tuser ? '0 : col_q;
	assign r_cur = s_tuser ? '0 : row_q;
	assign c_inc = CMPC_W'(c_cur) + CMPC_W'(1);
	assign r_inc = CMPR_W'(r_cur) + CMPR_W'(1);
	assign emit_cur = (c_cur >= COL_W'(2)) && (r_cur >= ROW_W'(2))
	               && (CMPC_W'(c_cur) < w_lim) && (CMPR_W'(r_cur) < h_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			if (c_inc >= w_lim) begin
				col_q <= '0;
				row_q <= (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
			end else begin
				col_q <= c_inc[COL_W-1:0];
				row_q <= r_cur;
			end
		end
	end

	// line store
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_eff;
	logic [LINE_W-1:0] line_wdata;
	logic [COL_W-1:0]  c_s1;
	logic [ROW_W-1:0]  r_s1;
	logic [PIX_W-1:0]  px_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic [PIX_W-1:0]  top;
	logic [PIX_W-1:0]  mid;

	veg_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (c_s1),
		.wdata (line_wdata),
		.re    (s_acc),
		.raddr (c_cur),
		.rdata (ram_rdata)
	);

	assign line_eff       = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign {top, mid}     = line_eff;
	assign line_wdata     = {mid, px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			emit_s1    <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
			emit_s1    <= emit_cur;
			fwd_s1     <= s1_adv && (c_s1 == c_cur);
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
			emit_s1    <= 1'b0;
			fwd_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			c_s1        <= c_cur;
			r_s1        <= r_cur;
			px_s1       <= s_tdata;
			fwd_data_s1 <= line_wdata;
		end
	end

	// window taps: [0..2] column c-1, [3..5] column c-2
	logic [PIX_W-1:0] tap_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				tap_q[i] <= '0;
			end
		end else if (s1_adv) begin
			tap_q[3] <= tap_q[0];
			tap_q[4] <= tap_q[1];
			tap_q[5] <= tap_q[2];
			tap_q[0] <= top;
			tap_q[1] <= mid;
			tap_q[2] <= px_s1;
		end
	end

	// gradient
	logic [PIX_W+1:0] sum_left;
	logic [PIX_W+1:0] sum_right;
	logic [PIX_W+2:0] diff;
	logic [PIX_W+1:0] diff_abs;
	logic [PIX_W-1:0] mag;

	assign sum_left  = (PIX_W+2)'(tap_q[3]) + (PIX_W+2)'(tap_q[4]) + (PIX_W+2)'(tap_q[5]);
	assign sum_right = (PIX_W+2)'(top) + (PIX_W+2)'(mid) + (PIX_W+2)'(px_s1);
	assign diff      = (PIX_W+3)'(sum_left) - (PIX_W+3)'(sum_right);
	assign diff_abs  = diff[PIX_W+2] ? (PIX_W+2)'(-diff) : diff[PIX_W+1:0];
	assign mag       = (diff_abs >= (PIX_W+2)'(1 << (PIX_W-1))) ? MAG_SAT
	                                                           : {diff_abs[PIX_W-2:0], 1'b0};

	// output register
	logic [PIX_W-1:0]     mag_q;
	logic [OUT_COL_W-1:0] ocol_q;
	logic [OUT_ROW_W-1:0] orow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			mag_q  <= mag;
			ocol_q <= OUT_COL_W'(c_s1 - COL_W'(1));
			orow_q <= OUT_ROW_W'(r_s1 - ROW_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({orow_q, ocol_q, mag_q});

	// checks
	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_valid_q)
		else $error("forward flag set with empty stage 1");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> !s_tready)
		else $error("request accepted while stage 1 stalled");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser) |=> (s1_valid_q && c_s1 == '0 && r_s1 == '0 && !emit_s1))
		else $error("frame start did not restart position");

	a_center_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ocol_q != '0 && orow_q != '0))
		else $error("result on a border center");

endmodule
